// File: sv/bouncing_circle_renderer_core_defines.svh
// Assertion helpers used by the renderer core.
`ifndef BOUNCING_CIRCLE_RENDERER_CORE_DEFINES_SVH
`define BOUNCING_CIRCLE_RENDERER_CORE_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define BCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off during reset.
`define BCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bcr_pkg.sv
package bcr_pkg;

  localparam int CIRCLE_COUNT = 3;
  localparam int IDX_W = (CIRCLE_COUNT > 1) ? $clog2(CIRCLE_COUNT) : 1;

  localparam int POS_W = 20;
  localparam int VEL_W = 13;
  localparam int RAD_W = 16;
  localparam int PIX_W = 10;
  localparam int LIM_W = PIX_W + 8;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  localparam logic [7:0] REG_FIELD_WIDTH  = 8'd0;
  localparam logic [7:0] REG_FIELD_HEIGHT = 8'd1;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic        [RAD_W-1:0] r;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } circle_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } probe_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             filled;
    logic [IDX_W-1:0] hit;
  } probe_res_t;

endpackage

// File: sv/bcr_cell.sv
module bcr_cell
  import bcr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  circle_t load_data_i,
  input  logic    shift_i,
  input  circle_t shift_data_i,
  output circle_t circle_o
);

  circle_t circle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circle_q <= '0;
    end else if (load_i) begin
      circle_q <= load_data_i;
    end else if (shift_i) begin
      circle_q <= shift_data_i;
    end
  end

  assign circle_o = circle_q;

endmodule

// File: sv/bcr_bounce.sv
module bcr_bounce
  import bcr_pkg::*;
(
  input  logic signed [POS_W-1:0] pos_i,
  input  logic signed [VEL_W-1:0] vel_i,
  input  logic        [RAD_W-1:0] rad_i,
  input  logic        [LIM_W-1:0] limit_i,
  output logic signed [POS_W-1:0] pos_o,
  output logic signed [VEL_W-1:0] vel_o
);

  localparam int EW = POS_W + 2;

  function automatic logic signed [VEL_W-1:0] neg_sat(input logic signed [VEL_W-1:0] v);
    logic signed [VEL_W-1:0] most_neg;
    most_neg = {1'b1, {(VEL_W-1){1'b0}}};
    if (v == most_neg) begin
      return ~most_neg;
    end
    return -v;
  endfunction

  logic signed [EW-1:0] p_e, r_e, lim_e, p1, sum;
  logic                 left, right;
  logic signed [VEL_W-1:0] v_neg, v1;

  always_comb begin
    p_e   = EW'(pos_i);
    r_e   = EW'($signed({1'b0, rad_i}));
    lim_e = EW'($signed({1'b0, limit_i}));
    left  = p_e < r_e;
    // the right test sees the centre as left by the left clamp
    right = left ? ((r_e + r_e) > lim_e) : ((p_e + r_e) > lim_e);
    if (right) begin
      p1 = lim_e - r_e;
    end else if (left) begin
      p1 = r_e;
    end else begin
      p1 = p_e;
    end
    v_neg = neg_sat(vel_i);
    if (left && right) begin
      v1 = neg_sat(v_neg);
    end else if (left || right) begin
      v1 = v_neg;
    end else begin
      v1 = vel_i;
    end
    sum = p1 + EW'(v1);
    if (sum > EW'($signed({1'b0, {(POS_W-1){1'b1}}}))) begin
      pos_o = {1'b0, {(POS_W-1){1'b1}}};
    end else if (sum < -EW'($signed({1'b0, 1'b1, {(POS_W-1){1'b0}}}))) begin
      pos_o = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_o = sum[POS_W-1:0];
    end
    vel_o = v1;
  end

endmodule

// File: sv/bcr_probe.sv
module bcr_probe
  import bcr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  probe_ctl_t       ctl_i,
  input  circle_t          circle_i,
  input  logic [PIX_W-1:0] pixel_x_i,
  input  logic [PIX_W-1:0] pixel_y_i,
  output probe_res_t       res_o
);

  localparam int DW = LIM_W + 3;        // signed pixel-minus-centre
  localparam int SW = 2 * DW - 2;       // square magnitude
  localparam int RSW = 2 * RAD_W;

  probe_ctl_t ctl1_q, ctl2_q;
  logic signed [DW-1:0]  dx1_q, dy1_q;
  logic [RAD_W-1:0]      r1_q;
  logic [SW-1:0]         dxs2_q, dys2_q;
  logic [RSW-1:0]        rs2_q;
  logic signed [2*DW-1:0] dxs, dys;
  logic                  found_q;
  logic [IDX_W-1:0]      hit_q;
  logic [SW:0]           dist_sum;
  logic                  in_circle, found_d;
  logic [IDX_W-1:0]      hit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q  <= '0;
      ctl2_q  <= '0;
      found_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      if (ctl2_q.valid) begin
        found_q <= found_d;
      end
    end
  end

  assign dxs = dx1_q * dx1_q;
  assign dys = dy1_q * dy1_q;

  always_ff @(posedge clk_i) begin
    dx1_q  <= DW'($signed({1'b0, pixel_x_i, 8'b0})) - DW'(circle_i.x);
    dy1_q  <= DW'($signed({1'b0, pixel_y_i, 8'b0})) - DW'(circle_i.y);
    r1_q   <= circle_i.r;
    dxs2_q <= dxs[SW-1:0];
    dys2_q <= dys[SW-1:0];
    rs2_q  <= r1_q * r1_q;
    if (ctl2_q.valid) begin
      hit_q <= hit_d;
    end
  end

  // the first circle of a query starts from an empty match
  always_comb begin
    dist_sum  = {1'b0, dxs2_q} + {1'b0, dys2_q};
    in_circle = dist_sum < (SW+1)'(rs2_q);
    found_d   = in_circle || (!ctl2_q.first && found_q);
    if (in_circle && (ctl2_q.first || !found_q)) begin
      hit_d = ctl2_q.idx;
    end else if (ctl2_q.first) begin
      hit_d = '0;
    end else begin
      hit_d = hit_q;
    end
    res_o.valid  = ctl2_q.valid && ctl2_q.last;
    res_o.filled = found_d;
    res_o.hit    = hit_d;
  end

endmodule

// File: sv/bouncing_circle_renderer_core.sv
// Bouncing circle renderer: a ring of circle cells with x and y bounce units
// and one distance unit at its head.
// Input stream s_axis: tuser carries the command (load, advance, query),
// tdata the circle fields and the pixel. Output stream m_axis: one word per
// input word, filled and circle_hit (zero for anything but a query).
// Configuration: cfg_valid_i/cfg_ready_o with register index 0 field width,
// 1 field height; write only while no word is in flight.
// Load and unused commands pass from input accept through the staging
// register into m_axis. Advance rotates all CIRCLE_COUNT cells through the
// bounce units, one per cycle. Query rotates the same ring through the
// two-stage squared-distance pipeline. The block takes no new word before
// the last is done: the next word is taken once the result has moved from
// the staging register into m_axis, so one result may wait in m_axis while
// the next word runs.
// Reset zeroes every circle and sets the field to 70 by 14 pixels.
// A stalled m_axis holds its word; once the staging register is also full,
// s_axis_tready stays low.
module bouncing_circle_renderer_core
  import bcr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // circle_index[1:0], load_x[21:2], load_y[41:22], load_radius[57:42],
  // load_vel_x[70:58], load_vel_y[83:71], pixel_x[93:84], pixel_y[103:94]
  input  logic [103:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // filled[0], circle_hit[2:1], zero[7:3]
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [9:0]   cfg_data_i
);

  `include "bouncing_circle_renderer_core_defines.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_WAIT
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CIRCLE_COUNT - 1);

  state_e           state_q;
  logic [IDX_W-1:0] cnt_q;
  logic             adv_q;
  logic             pend_q, m_valid_q;
  logic             pend_filled_q, out_filled_q;
  logic [1:0]       pend_hit_q, out_hit_q;
  logic [PIX_W-1:0] field_w_q, field_h_q, px_q, py_q;

  cmd_e       cmd;
  logic       in_fire, load_fire, rot_start, rot, last_step, out_load;
  logic       pend_set, pend_filled_d;
  logic [1:0] pend_hit_d;
  circle_t    load_data, tail_in, bounced;
  circle_t    cell_q [CIRCLE_COUNT];
  probe_ctl_t probe_ctl;
  probe_res_t probe_res;

  assign cmd           = cmd_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE) && !pend_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign load_fire     = in_fire && (cmd == CMD_LOAD);
  assign rot_start     = in_fire && ((cmd == CMD_ADVANCE) || (cmd == CMD_QUERY));
  assign rot           = (state_q == S_ROT);
  assign last_step     = rot && (cnt_q == LAST_IDX);
  assign out_load      = pend_q && (!m_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  assign load_data.x  = s_axis_tdata[21:2];
  assign load_data.y  = s_axis_tdata[41:22];
  assign load_data.r  = s_axis_tdata[57:42];
  assign load_data.vx = s_axis_tdata[70:58];
  assign load_data.vy = s_axis_tdata[83:71];

  // the head cell feeds the tail, through the bounce units on an advance
  for (genvar k = 0; k < CIRCLE_COUNT; k++) begin : g_ring
    circle_t shift_in;
    if (k == CIRCLE_COUNT - 1) begin : g_tail
      assign shift_in = tail_in;
    end else begin : g_mid
      assign shift_in = cell_q[k+1];
    end
    bcr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load_fire && (int'(s_axis_tdata[1:0]) == k)),
      .load_data_i (load_data),
      .shift_i     (rot),
      .shift_data_i(shift_in),
      .circle_o    (cell_q[k])
    );
  end

  bcr_bounce u_bounce_x (
    .pos_i  (cell_q[0].x),
    .vel_i  (cell_q[0].vx),
    .rad_i  (cell_q[0].r),
    .limit_i({field_w_q, 8'b0}),
    .pos_o  (bounced.x),
    .vel_o  (bounced.vx)
  );

  bcr_bounce u_bounce_y (
    .pos_i  (cell_q[0].y),
    .vel_i  (cell_q[0].vy),
    .rad_i  (cell_q[0].r),
    .limit_i({field_h_q, 8'b0}),
    .pos_o  (bounced.y),
    .vel_o  (bounced.vy)
  );

  assign bounced.r = cell_q[0].r;
  assign tail_in   = adv_q ? bounced : cell_q[0];

  assign probe_ctl.valid = rot && !adv_q;
  assign probe_ctl.first = (cnt_q == '0);
  assign probe_ctl.last  = (cnt_q == LAST_IDX);
  assign probe_ctl.idx   = cnt_q;

  bcr_probe u_probe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (probe_ctl),
    .circle_i (cell_q[0]),
    .pixel_x_i(px_q),
    .pixel_y_i(py_q),
    .res_o    (probe_res)
  );

  always_comb begin
    pend_set      = 1'b0;
    pend_filled_d = 1'b0;
    pend_hit_d    = 2'b00;
    if (in_fire && (cmd != CMD_ADVANCE) && (cmd != CMD_QUERY)) begin
      pend_set = 1'b1;
    end
    if (last_step && adv_q) begin
      pend_set = 1'b1;
    end
    if ((state_q == S_WAIT) && probe_res.valid) begin
      pend_set      = 1'b1;
      pend_filled_d = probe_res.filled;
      pend_hit_d    = 2'(probe_res.hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      adv_q     <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (rot_start) begin
            state_q <= S_ROT;
            cnt_q   <= '0;
            adv_q   <= (cmd == CMD_ADVANCE);
          end
        end
        S_ROT: begin
          if (last_step) begin
            state_q <= adv_q ? S_IDLE : S_WAIT;
            adv_q   <= 1'b0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_WAIT: begin
          if (probe_res.valid) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (pend_set) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q <= s_axis_tdata[93:84];
      py_q <= s_axis_tdata[103:94];
    end
    if (pend_set) begin
      pend_filled_q <= pend_filled_d;
      pend_hit_q    <= pend_hit_d;
    end
    if (out_load) begin
      out_filled_q <= pend_filled_q;
      out_hit_q    <= pend_hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_w_q <= 10'd70;
      field_h_q <= 10'd14;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_FIELD_WIDTH) begin
        field_w_q <= cfg_data_i;
      end else if (cfg_index_i == REG_FIELD_HEIGHT) begin
        field_h_q <= cfg_data_i;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, out_hit_q, out_filled_q};

  `BCR_ASSERT_NOW(a_cnt_range, (state_q == S_ROT), (cnt_q <= LAST_IDX), "count past last cell")
  `BCR_ASSERT_NEXT(a_rot_start, rot_start, (state_q == S_ROT), "ring did not start")
  `BCR_ASSERT_NOW(a_probe_wait, probe_res.valid, (state_q == S_WAIT), "result outside wait")
  `BCR_ASSERT_NOW(a_pend_idle, pend_q, (state_q == S_IDLE), "staged result while busy")

endmodule

// File: tb/sv/bouncing_circle_renderer_core_test.sv
module bouncing_circle_renderer_core_test
  import bcr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] REG_NONE = 8'd2;

  localparam longint POS_MIN = -524288;
  localparam longint POS_MAX = 524287;
  localparam longint VEL_MIN = -4096;
  localparam longint VEL_MAX = 4095;

  // s_axis_tdata layout, lowest field last
  typedef struct packed {
    logic        [PIX_W-1:0] py;
    logic        [PIX_W-1:0] px;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vx;
    logic        [RAD_W-1:0] r;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
    logic        [1:0]       idx;
  } word_t;

  // m_axis_tdata layout, lowest field last
  typedef struct packed {
    logic [1:0] hit;
    logic       filled;
  } pixel_result_t;

  typedef struct packed {
    logic signed [POS_W-1:0] p;
    logic signed [VEL_W-1:0] v;
  } axis_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i;
  logic [9:0]   cfg_data_i;

  circle_t       circle_tab [CIRCLE_COUNT];
  logic [9:0]    field_w;
  logic [9:0]    field_h;
  pixel_result_t pixel_results_q[$];
  int            errors;
  bit            src_idle_en;
  bit            sink_idle_en;
  int            sink_hold;

  bouncing_circle_renderer_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic axis_t bounce_axis(axis_t a, longint r, longint lim);
    longint p;
    longint v;
    axis_t  o;
    p = longint'($signed(a.p));
    v = longint'($signed(a.v));
    if (p - r < 0) begin
      v = sat(-v, VEL_MIN, VEL_MAX);
      p = r;
    end
    if (p + r > lim) begin
      v = sat(-v, VEL_MIN, VEL_MAX);
      p = lim - r;
    end
    p = sat(p, POS_MIN, POS_MAX);
    p = sat(p + v, POS_MIN, POS_MAX);
    o.p = p[POS_W-1:0];
    o.v = v[VEL_W-1:0];
    return o;
  endfunction

  // Advance the circle table by one word and return the pixel result it yields.
  function automatic pixel_result_t scene_step(cmd_e cmd, word_t w);
    pixel_result_t res;
    axis_t         ax;
    longint        r;
    longint        dx;
    longint        dy;
    res = '0;
    case (cmd)
      CMD_LOAD: begin
        if (w.idx < CIRCLE_COUNT) begin
          circle_tab[w.idx].x  = w.x;
          circle_tab[w.idx].y  = w.y;
          circle_tab[w.idx].r  = w.r;
          circle_tab[w.idx].vx = w.vx;
          circle_tab[w.idx].vy = w.vy;
        end
      end
      CMD_ADVANCE: begin
        for (int i = 0; i < CIRCLE_COUNT; i++) begin
          r  = longint'(circle_tab[i].r);
          ax = bounce_axis({circle_tab[i].x, circle_tab[i].vx}, r, longint'(field_w) * 256);
          circle_tab[i].x  = ax.p;
          circle_tab[i].vx = ax.v;
          ax = bounce_axis({circle_tab[i].y, circle_tab[i].vy}, r, longint'(field_h) * 256);
          circle_tab[i].y  = ax.p;
          circle_tab[i].vy = ax.v;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < CIRCLE_COUNT; i++) begin
          dx = longint'(w.px) * 256 - longint'($signed(circle_tab[i].x));
          dy = longint'(w.py) * 256 - longint'($signed(circle_tab[i].y));
          r  = longint'(circle_tab[i].r);
          if (!res.filled && (dx * dx + dy * dy < r * r)) begin
            res.filled = 1'b1;
            res.hit    = 2'(i);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic word_t load_word(logic [1:0] idx, int x, int y, int r, int vx, int vy);
    word_t w;
    w    = '0;
    w.idx = idx;
    w.x  = POS_W'(x);
    w.y  = POS_W'(y);
    w.r  = RAD_W'(r);
    w.vx = VEL_W'(vx);
    w.vy = VEL_W'(vy);
    return w;
  endfunction

  function automatic word_t query_word(int px, int py);
    word_t w;
    w    = '0;
    w.px = PIX_W'(px);
    w.py = PIX_W'(py);
    return w;
  endfunction

  function automatic word_t rand_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[103:0];
  endfunction

  task automatic send_word(cmd_e cmd, word_t w);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixel_results_q.push_back(scene_step(cmd, w));
  endtask

  // Drop valid and wait until every result has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pixel_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [9:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_FIELD_WIDTH) field_w = data;
    else if (idx == REG_FIELD_HEIGHT) field_h = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_word(int fw, int fh);
    word_t w;
    int    sel;
    int    c;
    int    px;
    int    py;
    sel = $urandom_range(0, 99);
    w   = rand_word();
    if (sel < 25) begin
      // mostly circles that sit inside the field and move at a sane speed
      if ($urandom_range(0, 9) != 0) begin
        w = load_word(($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                      $urandom_range(0, fw * 256), $urandom_range(0, fh * 256),
                      $urandom_range(0, 12 * 256),
                      int'($urandom_range(0, 1536)) - 768,
                      int'($urandom_range(0, 1536)) - 768);
      end
      send_word(CMD_LOAD, w);
    end else if (sel < 55) begin
      send_word(CMD_ADVANCE, w);
    end else if (sel < 97) begin
      if ($urandom_range(0, 9) < 7) begin
        c  = $urandom_range(0, CIRCLE_COUNT - 1);
        px = int'($signed(circle_tab[c].x)) / 256 + int'($urandom_range(0, 16)) - 8;
        py = int'($signed(circle_tab[c].y)) / 256 + int'($urandom_range(0, 16)) - 8;
        px = int'(sat(px, 0, 1023));
        py = int'(sat(py, 0, 1023));
        w.px = PIX_W'(px);
        w.py = PIX_W'(py);
      end
      send_word(CMD_QUERY, w);
    end else begin
      send_word(CMD_UNUSED, w);
    end
  endtask

  task automatic test_reset_state();
    send_word(CMD_QUERY, query_word(0, 0));
    send_word(CMD_ADVANCE, '0);
    send_word(CMD_QUERY, query_word(0, 0));
    drain();
  endtask

  task automatic test_load_and_query();
    cfg_write(REG_FIELD_WIDTH, 10'd70);
    cfg_write(REG_FIELD_HEIGHT, 10'd14);
    cfg_write(REG_NONE, 10'h3FF);
    send_word(CMD_LOAD, load_word(2'd0, 10 * 256, 7 * 256, 3 * 256, 0, 0));
    send_word(CMD_LOAD, load_word(2'd1, 12 * 256, 7 * 256, 3 * 256, -64, 32));
    send_word(CMD_LOAD, load_word(2'd2, -524288, 524287, 65535, -4096, 4095));
    // index past the table: ignored
    send_word(CMD_LOAD, load_word(2'd3, 0, 0, 65535, 4095, 4095));
    send_word(CMD_QUERY, query_word(10, 7));
    // on the rim of circle 0, inside circle 1
    send_word(CMD_QUERY, query_word(13, 7));
    send_word(CMD_QUERY, query_word(0, 0));
    send_word(CMD_QUERY, query_word(1023, 1023));
    send_word(CMD_UNUSED, '1);
    drain();
  endtask

  task automatic test_wall_bounce();
    cfg_write(REG_FIELD_WIDTH, 10'd1);
    cfg_write(REG_FIELD_HEIGHT, 10'd1023);
    // wider than the field: both walls hit in one frame
    send_word(CMD_LOAD, load_word(2'd0, 0, 0, 512, -4096, -4096));
    send_word(CMD_ADVANCE, '0);
    send_word(CMD_ADVANCE, '0);
    send_word(CMD_QUERY, query_word(1, 1));
    drain();
    cfg_write(REG_FIELD_WIDTH, 10'd1023);
    cfg_write(REG_FIELD_HEIGHT, 10'd1);
    send_word(CMD_LOAD, load_word(2'd1, 1023 * 256 - 10, 128, 1000, 4095, -4096));
    send_word(CMD_ADVANCE, '0);
    send_word(CMD_QUERY, query_word(1023, 0));
    send_word(CMD_QUERY, query_word(0, 0));
    drain();
  endtask

  task automatic test_random_traffic();
    int fw;
    int fh;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0) begin
        fw = $urandom_range(0, 1) ? 1023 : 1;
        fh = $urandom_range(0, 1) ? 1023 : 1;
      end else begin
        fw = $urandom_range(1, 200);
        fh = $urandom_range(1, 200);
      end
      cfg_write(REG_FIELD_WIDTH, 10'(fw));
      cfg_write(REG_FIELD_HEIGHT, 10'(fh));
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      repeat (50) send_random_word(fw, fh);
      drain();
    end
  endtask

  // Stall the output long enough that the block backs up into its input.
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    sink_hold    = 60;
    repeat (40) send_random_word(int'(field_w), int'(field_h));
    drain();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Output side: stall at random, check each word against the oldest prediction.
  initial begin
    int            stall;
    pixel_result_t want;
    pixel_result_t got;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(negedge clk_i);
        sink_hold = 0;
      end else begin
        stall = sink_idle_en ? $urandom_range(0, 3) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = m_axis_tdata[2:0];
      if (pixel_results_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual filled %0b hit %0d",
                 $time, got.filled, got.hit);
        errors++;
      end else begin
        want = pixel_results_q.pop_front();
        if (got.filled !== want.filled) begin
          $display("%0t: filled mismatch, expected %0b actual %0b",
                   $time, want.filled, got.filled);
          errors++;
        end
        if (got.hit !== want.hit) begin
          $display("%0t: circle_hit mismatch, expected %0d actual %0d",
                   $time, want.hit, got.hit);
          errors++;
        end
      end
    end
  end

  initial begin
    #200000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_LOAD;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_FIELD_WIDTH;
    cfg_data_i    = '0;
    errors        = 0;
    sink_hold     = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    field_w       = 10'd70;
    field_h       = 10'd14;
    for (int i = 0; i < CIRCLE_COUNT; i++) circle_tab[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_load_and_query();
    test_wall_bounce();
    test_random_traffic();
    test_backpressure();

    repeat (16) @(posedge clk_i);
    if (errors == 0 && pixel_results_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
